@@ hw/rtl/pst_pkg.sv @@
// Package for the pairwise span tracker: field widths, status codes and the
// command and status structs that join the controller to the datapath.
// Depends on nothing.
package pst_pkg;

   localparam int WORD_W = 32;
   localparam int COUNT_W = 11;
   localparam int CAPACITY_MAX_DEFAULT = 1024;

   localparam logic [WORD_W-1:0] SIGN_FLIP = 32'h8000_0000;
   localparam logic [WORD_W-1:0] GAP_NONE = '1;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic take;
      logic reject;
      logic scan_issue;
      logic write;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic idx_last;
      logic pipe_busy;
   } stat_type;

endpackage

@@ hw/rtl/pst_req_if.sv @@
// Request channel of the pairwise span tracker: valid, ready and the payload.
// Depends on pst_pkg.
interface pst_req_if;
   import pst_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] value;
   logic              new_set;

   modport source (output valid, output value, output new_set, input ready);
   modport sink (input valid, input value, input new_set, output ready);
endinterface

@@ hw/rtl/pst_rsp_if.sv @@
// Response channel of the pairwise span tracker: valid, ready and the payload.
// Depends on pst_pkg.
interface pst_rsp_if;
   import pst_pkg::*;

   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  shortest_span;
   logic [WORD_W-1:0]  longest_span;
   logic               span_valid;
   logic               status;
   logic [COUNT_W-1:0] held_count;

   modport source (output valid, output shortest_span, output longest_span,
                   output span_valid, output status, output held_count, input ready);
   modport sink (input valid, input shortest_span, input longest_span,
                 input span_valid, input status, input held_count, output ready);
endinterface

@@ hw/rtl/pairwise_span_tracker.sv @@
// Top level of the pairwise span tracker: channel wiring, controller and
// datapath. Depends on pst_pkg, pst_req_if, pst_rsp_if, pst_ctrl and pst_dp.
//
// The block keeps a set of signed 32-bit numbers and, after every request,
// reports the smallest and the largest difference between any two of them.
// A request on req_ch carries one number and a new_set flag; new_set empties
// the set before the number is taken. Exactly one response leaves on rsp_ch
// for each request. Its status is full when the set already holds the number
// of entries given by the capacity register, in which case the number is
// dropped and the response describes the unchanged set. The spans read zero
// and span_valid is low while fewer than two numbers are held.
//
// Users write capacity via csr_wr_en/csr_wr_data only while the block is
// idle (unenforced); values above the store depth act as the depth.
//
// A request that is stored when numbers are already held goes through the
// check, scan, drain, write and finish states; the first number of a set
// skips the scan and drain, and a rejected request goes from the check
// straight to finish. The new number is compared against each held number
// in turn, one store read per cycle, and the next request can be taken in
// the cycle after the response is loaded, so requests are handled singly.
// The response sits in an output register, so a stalled receiver does not
// keep the next request out; only a second finished result waits for the
// first to be taken.
// Reset empties the set, clears the capacity to zero and drops any response.
module pairwise_span_tracker #(
   parameter int CAPACITY_MAX = pst_pkg::CAPACITY_MAX_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   pst_req_if.sink                     req_ch,
   pst_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [pst_pkg::COUNT_W-1:0] csr_wr_data
);
   import pst_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller decides when requests and responses move; the
   // datapath only reacts to its commands.
   pst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pst_dp #(
      .CAPACITY_MAX (CAPACITY_MAX)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_value         (req_ch.value),
      .req_new_set       (req_ch.new_set),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_shortest_span (rsp_ch.shortest_span),
      .rsp_longest_span  (rsp_ch.longest_span),
      .rsp_span_valid    (rsp_ch.span_valid),
      .rsp_status        (rsp_ch.status),
      .rsp_held_count    (rsp_ch.held_count)
   );
endmodule

@@ hw/rtl/pst_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module pst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/pst_ctrl.sv @@
// Controller of the pairwise span tracker: sequences check, scan, write and
// response load, and owns the request ready and response valid.
// Depends on pst_pkg.
module pst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pst_pkg::stat_type stat,
   output pst_pkg::cmd_type  cmd
);
   import pst_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.full) begin
               cmd.reject = 1'b1;
               state_in = ST_FINISH;
            end else if (stat.empty) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A result is only loaded into a free or emptying output register.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> out_free)
      else $error("response loaded over an unread response");

   // An accepted request always goes on to the capacity check.
   a_take_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_CHECK)
      else $error("accepted request did not reach the check");
endmodule

@@ hw/rtl/pst_dp.sv @@
// Datapath of the pairwise span tracker: capacity register, number store,
// scan pipeline for the smallest gap, running extremes and response register.
// Depends on pst_pkg and pst_ram.
module pst_dp #(
   parameter int CAPACITY_MAX = pst_pkg::CAPACITY_MAX_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pst_pkg::WORD_W-1:0]  req_value,
   input  logic                        req_new_set,
   input  logic                        csr_wr_en,
   input  logic [pst_pkg::COUNT_W-1:0] csr_wr_data,
   input  pst_pkg::cmd_type            cmd,
   output pst_pkg::stat_type           stat,
   output logic [pst_pkg::WORD_W-1:0]  rsp_shortest_span,
   output logic [pst_pkg::WORD_W-1:0]  rsp_longest_span,
   output logic                        rsp_span_valid,
   output logic                        rsp_status,
   output logic [pst_pkg::COUNT_W-1:0] rsp_held_count
);
   import pst_pkg::*;

   localparam int AW = $clog2(CAPACITY_MAX);

   logic [COUNT_W-1:0] capacity_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] idx_ff;
   logic [WORD_W-1:0]  value_ff;
   logic [WORD_W-1:0]  least_ff;
   logic [WORD_W-1:0]  greatest_ff;
   logic [WORD_W-1:0]  gap_ff;
   logic               reject_ff;
   logic               rd_valid_ff;
   logic               diff_valid_ff;
   logic [WORD_W-1:0]  diff_ff;
   logic [WORD_W-1:0]  shortest_ff;
   logic [WORD_W-1:0]  longest_ff;
   logic               span_valid_ff;
   logic               status_ff;
   logic [COUNT_W-1:0] held_ff;

   logic [WORD_W-1:0]  rd_data;
   logic [COUNT_W-1:0] usable;
   logic               two_held;

   pst_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (AW'(count_ff)),
      .wr_data (value_ff),
      .rd_addr (AW'(idx_ff)),
      .rd_data (rd_data)
   );

   // Capacity above the store depth saturates to the depth.
   assign usable = (32'(capacity_ff) > 32'(CAPACITY_MAX)) ? COUNT_W'(CAPACITY_MAX)
                                                           : capacity_ff;
   assign two_held = count_ff >= COUNT_W'(2);

   assign stat.full = count_ff >= usable;
   assign stat.empty = count_ff == '0;
   assign stat.idx_last = COUNT_W'(idx_ff + COUNT_W'(1)) == count_ff;
   assign stat.pipe_busy = rd_valid_ff || diff_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
         count_ff <= '0;
         least_ff <= '0;
         greatest_ff <= '0;
         gap_ff <= GAP_NONE;
         rd_valid_ff <= 1'b0;
         diff_valid_ff <= 1'b0;
         reject_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         rd_valid_ff <= cmd.scan_issue;
         diff_valid_ff <= rd_valid_ff;
         if (cmd.take) begin
            idx_ff <= '0;
            reject_ff <= 1'b0;
            if (req_new_set) begin
               count_ff <= '0;
               least_ff <= '0;
               greatest_ff <= '0;
               gap_ff <= GAP_NONE;
            end
         end
         if (cmd.reject) begin
            reject_ff <= 1'b1;
         end
         if (cmd.scan_issue) begin
            idx_ff <= COUNT_W'(idx_ff + COUNT_W'(1));
         end
         if (diff_valid_ff && diff_ff < gap_ff) begin
            gap_ff <= diff_ff;
         end
         if (cmd.write) begin
            count_ff <= COUNT_W'(count_ff + COUNT_W'(1));
            if (count_ff == '0) begin
               least_ff <= value_ff;
               greatest_ff <= value_ff;
            end else begin
               if (value_ff < least_ff) begin
                  least_ff <= value_ff;
               end
               if (value_ff > greatest_ff) begin
                  greatest_ff <= value_ff;
               end
            end
         end
      end
   end

   // Payload registers: the biased value, the gap stage and the response.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         value_ff <= req_value ^ SIGN_FLIP;
      end
      diff_ff <= (rd_data > value_ff) ? (rd_data - value_ff) : (value_ff - rd_data);
      if (cmd.load_rsp) begin
         shortest_ff <= two_held ? gap_ff : '0;
         longest_ff <= two_held ? (greatest_ff - least_ff) : '0;
         span_valid_ff <= two_held;
         status_ff <= reject_ff ? STATUS_FULL : STATUS_OK;
         held_ff <= count_ff;
      end
   end

   assign rsp_shortest_span = shortest_ff;
   assign rsp_longest_span = longest_ff;
   assign rsp_span_valid = span_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_held_count = held_ff;

   // A number is only written into a store that still has room.
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> !stat.full)
      else $error("number written into a full store");

   // The scan never walks past the held numbers.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |-> idx_ff < count_ff)
      else $error("scan index beyond the held count");

   // The count never exceeds the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY_MAX))
      else $error("held count exceeds the store depth");
endmodule
